// ===== hw/rtl/clrq_pkg.sv =====
`default_nettype none
package clrq_pkg;

  localparam int NUM_IDS = 32;
  localparam int ID_W    = 5;
  localparam int CNT_W   = 6;
  localparam int RES_W   = 3;
  localparam int CMD_W   = 2;
  localparam int GUARD_W = $clog2(NUM_IDS + 1);

  localparam logic [CNT_W-1:0] MAX_ACTIVE_RST = CNT_W'(16);

  localparam logic [CMD_W-1:0] CMD_ACTIVATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

  localparam logic [RES_W-1:0] RES_ISSUED   = 3'd0;
  localparam logic [RES_W-1:0] RES_FAILED   = 3'd1;
  localparam logic [RES_W-1:0] RES_QUEUED   = 3'd2;
  localparam logic [RES_W-1:0] RES_FREED    = 3'd3;
  localparam logic [RES_W-1:0] RES_UNQUEUED = 3'd4;
  localparam logic [RES_W-1:0] RES_IGNORED  = 3'd5;

  localparam logic REG_MAX_ACTIVE = 1'b0;
  localparam logic REG_ONLINE     = 1'b1;

  typedef enum logic [2:0] {
    DEC_IGNORE,
    DEC_QUEUE,
    DEC_ISSUE,
    DEC_FREE,
    DEC_UNQUEUE
  } dec_kind_t;

  typedef struct packed {
    dec_kind_t kind;
    logic      pend_empty;
    logic      out_free;
    logic      online;
    logic      guard_done;
  } dp_status_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic promote;
    logic unlink;
    logic unq_emit;
    logic act;
  } dp_cmd_t;

  function automatic logic [ID_W-1:0] safe_idx(input logic [ID_W-1:0] i);
    return (CNT_W'(i) < CNT_W'(NUM_IDS)) ? i : '0;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/clrq_if.sv =====
`default_nettype none
interface clrq_req_if;
  logic                        valid;
  logic                        ready;
  logic [clrq_pkg::CMD_W-1:0]  cmd;
  logic [clrq_pkg::ID_W-1:0]   req_id;

  modport source (output valid, output cmd, output req_id, input ready);
  modport sink (input valid, input cmd, input req_id, output ready);
endinterface

interface clrq_evt_if;
  logic                        valid;
  logic                        ready;
  logic [clrq_pkg::RES_W-1:0]  event_res;
  logic [clrq_pkg::ID_W-1:0]   event_id;
  logic [clrq_pkg::CNT_W-1:0]  active_count;
  logic                        last;

  modport source (output valid, output event_res, output event_id, output active_count,
                  output last, input ready);
  modport sink (input valid, input event_res, input event_id, input active_count,
                input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/concurrency_limited_request_queue_top.sv =====
// Flow: a word is taken in the idle state and decoded in the decode state, where its first
// result is registered; an activation that is issued or fails adds the activation step.
// A new word is taken only in the idle state, after the last one is through; an unqueued
// word adds the unlink step, and each id promoted from the pending list adds the head read,
// unlink and activate steps; a result held by the receiver delays the step that emits the next one.
// Reset: synchronous rst clears all flags, the pending list and the counters, and sets
// max_active to 16 and online to 1; the link memories are not cleared.
`default_nettype none
module concurrency_limited_request_queue_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic                       wr_index,
  input  wire logic [clrq_pkg::CNT_W-1:0] wr_data,
  clrq_req_if.sink                        req,
  clrq_evt_if.source                      evt
);

  clrq_pkg::dp_status_t sts;
  clrq_pkg::dp_cmd_t    ctl;

  clrq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  clrq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .in_cmd    (req.cmd),
    .in_req_id (req.req_id),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (evt.valid),
    .out_ready (evt.ready),
    .out_res   (evt.event_res),
    .out_id    (evt.event_id),
    .out_count (evt.active_count),
    .out_last  (evt.last)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/clrq_ctrl.sv =====
`default_nettype none
module clrq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire clrq_pkg::dp_status_t sts,
  output clrq_pkg::dp_cmd_t         ctl
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_PROMO  = 6'b000100,
    ST_UNL_P  = 6'b001000,
    ST_UNL_C  = 6'b010000,
    ST_ACT    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.out_free) begin
          ctl.decode = 1'b1;
          case (sts.kind)
            clrq_pkg::DEC_ISSUE:   state_next = ST_ACT;
            clrq_pkg::DEC_FREE:    state_next = sts.pend_empty ? ST_IDLE : ST_PROMO;
            clrq_pkg::DEC_UNQUEUE: state_next = ST_UNL_C;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_PROMO: begin
        ctl.promote = 1'b1;
        state_next  = ST_UNL_P;
      end
      ST_UNL_P: begin
        ctl.unlink = 1'b1;
        state_next = ST_ACT;
      end
      ST_UNL_C: begin
        if (sts.out_free) begin
          ctl.unlink   = 1'b1;
          ctl.unq_emit = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_ACT: begin
        if (sts.out_free) begin
          ctl.act = 1'b1;
          if (sts.online || sts.guard_done) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_PROMO;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/clrq_datapath.sv =====
`default_nettype none
module clrq_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic                        wr_index,
  input  wire logic [clrq_pkg::CNT_W-1:0]  wr_data,
  input  wire logic [clrq_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [clrq_pkg::ID_W-1:0]   in_req_id,
  input  wire clrq_pkg::dp_cmd_t           ctl,
  output clrq_pkg::dp_status_t             sts,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [clrq_pkg::RES_W-1:0]       out_res,
  output logic [clrq_pkg::ID_W-1:0]        out_id,
  output logic [clrq_pkg::CNT_W-1:0]       out_count,
  output logic                             out_last
);

  localparam int N    = clrq_pkg::NUM_IDS;
  localparam int IW   = clrq_pkg::ID_W;
  localparam int CW   = clrq_pkg::CNT_W;
  localparam int GW   = clrq_pkg::GUARD_W;

  logic [clrq_pkg::CMD_W-1:0] cur_cmd;
  logic [IW-1:0]              cur_id;
  logic [N-1:0]               act_flags;
  logic [N-1:0]               pend_flags;
  logic [IW-1:0]              head;
  logic [IW-1:0]              tail;
  logic [CW-1:0]              active_total;
  logic [CW-1:0]              pending_total;
  logic [CW-1:0]              max_active;
  logic                       online;
  logic [GW-1:0]              guard;

  logic [IW-1:0] next_mem [N];
  logic [IW-1:0] prev_mem [N];
  logic [IW-1:0] next_rd;
  logic [IW-1:0] prev_rd;
  logic [IW-1:0] rd_addr;

  logic          next_we;
  logic [IW-1:0] next_wa;
  logic [IW-1:0] next_wd;
  logic          prev_we;
  logic [IW-1:0] prev_wa;
  logic [IW-1:0] prev_wd;

  logic          emit;
  logic [clrq_pkg::RES_W-1:0] emit_res;
  logic [CW-1:0] emit_count;
  logic          emit_last;

  logic [IW-1:0] idx;
  logic          id_bad;
  logic [IW-1:0] nx;
  logic [IW-1:0] pv;
  logic          is_head;
  logic          is_tail;
  logic [CW-1:0] pend_after;
  logic          pend_empty;
  logic          guard_done;
  clrq_pkg::dec_kind_t kind;

  assign idx        = clrq_pkg::safe_idx(cur_id);
  assign id_bad     = CW'(cur_id) >= CW'(N);
  assign nx         = clrq_pkg::safe_idx(next_rd);
  assign pv         = clrq_pkg::safe_idx(prev_rd);
  assign is_head    = cur_id == head;
  assign is_tail    = cur_id == tail;
  assign pend_after = pending_total - CW'(1);
  assign pend_empty = pending_total == '0;
  assign guard_done = pend_empty || (CW'(guard) >= CW'(N));
  assign rd_addr    = ctl.promote ? clrq_pkg::safe_idx(head) : idx;

  always_comb begin
    if (id_bad || cur_cmd == clrq_pkg::CMD_NONE) begin
      kind = clrq_pkg::DEC_IGNORE;
    end else if (cur_cmd == clrq_pkg::CMD_ACTIVATE) begin
      if (act_flags[idx] || pend_flags[idx]) begin
        kind = clrq_pkg::DEC_IGNORE;
      end else if (active_total >= max_active) begin
        kind = clrq_pkg::DEC_QUEUE;
      end else begin
        kind = clrq_pkg::DEC_ISSUE;
      end
    end else if (act_flags[idx]) begin
      kind = clrq_pkg::DEC_FREE;
    end else if (cur_cmd == clrq_pkg::CMD_CANCEL && pend_flags[idx]) begin
      kind = clrq_pkg::DEC_UNQUEUE;
    end else begin
      kind = clrq_pkg::DEC_IGNORE;
    end
  end

  assign sts.kind       = kind;
  assign sts.pend_empty = pend_empty;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.online     = online;
  assign sts.guard_done = guard_done;

  always_comb begin
    emit       = 1'b0;
    emit_res   = clrq_pkg::RES_IGNORED;
    emit_count = active_total;
    emit_last  = 1'b1;
    next_we    = 1'b0;
    next_wa    = clrq_pkg::safe_idx(tail);
    next_wd    = cur_id;
    prev_we    = 1'b0;
    prev_wa    = idx;
    prev_wd    = tail;
    if (ctl.decode) begin
      case (kind)
        clrq_pkg::DEC_IGNORE: begin
          emit = 1'b1;
        end
        clrq_pkg::DEC_QUEUE: begin
          emit     = 1'b1;
          emit_res = clrq_pkg::RES_QUEUED;
          next_we  = !pend_empty;
          prev_we  = !pend_empty;
        end
        clrq_pkg::DEC_FREE: begin
          emit       = 1'b1;
          emit_res   = clrq_pkg::RES_FREED;
          emit_count = active_total - CW'(1);
          emit_last  = pend_empty;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    if (ctl.unlink && pend_after != '0) begin
      next_we = !is_head;
      next_wa = pv;
      next_wd = nx;
      prev_we = !is_tail;
      prev_wa = nx;
      prev_wd = pv;
    end
    if (ctl.unq_emit) begin
      emit     = 1'b1;
      emit_res = clrq_pkg::RES_UNQUEUED;
    end
    if (ctl.act) begin
      emit = 1'b1;
      if (online) begin
        emit_res   = clrq_pkg::RES_ISSUED;
        emit_count = active_total + CW'(1);
      end else begin
        emit_res  = clrq_pkg::RES_FAILED;
        emit_last = guard_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    next_rd <= next_mem[rd_addr];
    prev_rd <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur_cmd <= in_cmd;
      cur_id  <= in_req_id;
    end else if (ctl.promote) begin
      cur_id <= clrq_pkg::safe_idx(head);
    end
    if (emit) begin
      out_res   <= emit_res;
      out_id    <= cur_id;
      out_count <= emit_count;
      out_last  <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_flags     <= '0;
      pend_flags    <= '0;
      head          <= '0;
      tail          <= '0;
      active_total  <= '0;
      pending_total <= '0;
      max_active    <= clrq_pkg::MAX_ACTIVE_RST;
      online        <= 1'b1;
      guard         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          clrq_pkg::REG_MAX_ACTIVE: max_active <= wr_data;
          clrq_pkg::REG_ONLINE:     online     <= wr_data[0];
          default:                  online     <= online;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.decode) begin
        guard <= '0;
        case (kind)
          clrq_pkg::DEC_QUEUE: begin
            if (pend_empty) begin
              head <= cur_id;
            end
            tail            <= cur_id;
            pend_flags[idx] <= 1'b1;
            pending_total   <= pending_total + CW'(1);
          end
          clrq_pkg::DEC_FREE: begin
            act_flags[idx] <= 1'b0;
            active_total   <= active_total - CW'(1);
          end
          default: begin
            guard <= '0;
          end
        endcase
      end
      if (ctl.unlink) begin
        pend_flags[idx] <= 1'b0;
        pending_total   <= pend_after;
        if (pend_after == '0) begin
          head <= '0;
          tail <= '0;
        end else begin
          if (is_head) begin
            head <= nx;
          end
          if (is_tail) begin
            tail <= pv;
          end
        end
      end
      if (ctl.act) begin
        if (online) begin
          act_flags[idx] <= 1'b1;
          active_total   <= active_total + CW'(1);
        end else if (!guard_done) begin
          guard <= guard + GW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/clrq_checker.sv =====
`default_nettype none
module clrq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       evt_valid,
  input wire logic                       evt_ready,
  input wire logic [clrq_pkg::RES_W-1:0] evt_res,
  input wire logic [clrq_pkg::CNT_W-1:0] evt_count,
  input wire logic                       evt_last
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !evt_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid)
    else $error("stalled result dropped");

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> evt_res <= clrq_pkg::RES_IGNORED)
    else $error("result code out of range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> evt_count <= clrq_pkg::CNT_W'(clrq_pkg::NUM_IDS))
    else $error("active count above id count");

  a_final_codes: assert property (@(posedge clk) disable iff (rst)
    evt_valid && (evt_res == clrq_pkg::RES_ISSUED || evt_res == clrq_pkg::RES_QUEUED ||
                  evt_res == clrq_pkg::RES_UNQUEUED || evt_res == clrq_pkg::RES_IGNORED)
    |-> evt_last)
    else $error("terminal result without last");

endmodule

bind concurrency_limited_request_queue_top clrq_checker u_clrq_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .evt_res   (evt.event_res),
  .evt_count (evt.active_count),
  .evt_last  (evt.last)
);
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import clrq_pkg::*;

  typedef struct {
    logic [RES_W-1:0] res;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    logic             last;
  } event_word_t;

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic             wr_index;
  logic [CNT_W-1:0] wr_data;

  clrq_req_if req_ch ();
  clrq_evt_if evt_ch ();

  concurrency_limited_request_queue_top uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .req      (req_ch),
    .evt      (evt_ch)
  );

  // Shadow of the request tracker.
  logic [NUM_IDS-1:0] active_map;
  logic [NUM_IDS-1:0] waiting_map;
  logic [ID_W-1:0]    link_next [NUM_IDS];
  logic [ID_W-1:0]    link_prev [NUM_IDS];
  logic [ID_W-1:0]    wait_head;
  logic [ID_W-1:0]    wait_tail;
  int                 active_total;
  int                 waiting_total;
  int                 limit_cfg;
  bit                 online_cfg;

  event_word_t due_events[$];
  int          fail_count;
  bit          idle_on;
  int          hold_cnt;
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(24, 6);
  endfunction

  function automatic void clear_tracker();
    active_map    = '0;
    waiting_map   = '0;
    wait_head     = '0;
    wait_tail     = '0;
    active_total  = 0;
    waiting_total = 0;
    limit_cfg     = 16;
    online_cfg    = 1'b1;
    for (int k = 0; k < NUM_IDS; k++) begin
      link_next[k] = '0;
      link_prev[k] = '0;
    end
  endfunction

  function automatic void log_event(logic [RES_W-1:0] res, logic [ID_W-1:0] id);
    event_word_t w;
    w.res   = res;
    w.id    = id;
    w.count = active_total[CNT_W-1:0];
    w.last  = 1'b0;
    due_events.push_back(w);
  endfunction

  function automatic void append_waiting(logic [ID_W-1:0] id);
    if (waiting_total == 0) begin
      wait_head = id;
    end else begin
      link_next[wait_tail] = id;
      link_prev[id] = wait_tail;
    end
    wait_tail = id;
    waiting_map[id] = 1'b1;
    waiting_total++;
  endfunction

  function automatic void remove_waiting(logic [ID_W-1:0] id);
    logic [ID_W-1:0] nx;
    logic [ID_W-1:0] pv;
    logic            at_head;
    logic            at_tail;
    nx = link_next[id];
    pv = link_prev[id];
    at_head = (id == wait_head);
    at_tail = (id == wait_tail);
    waiting_map[id] = 1'b0;
    waiting_total--;
    if (waiting_total == 0) begin
      wait_head = '0;
      wait_tail = '0;
      return;
    end
    if (at_head) wait_head = nx;
    else link_next[pv] = nx;
    if (at_tail) wait_tail = pv;
    else link_prev[nx] = pv;
  endfunction

  // While offline, each failed id hands its slot to the next waiting id.
  function automatic void issue_or_fail(logic [ID_W-1:0] id);
    int              guard;
    logic [ID_W-1:0] cur;
    guard = 0;
    cur = id;
    while (1) begin
      if (online_cfg) begin
        active_map[cur] = 1'b1;
        active_total++;
        log_event(RES_ISSUED, cur);
        return;
      end
      log_event(RES_FAILED, cur);
      if (waiting_total == 0 || guard >= NUM_IDS) return;
      guard++;
      cur = wait_head;
      remove_waiting(cur);
    end
  endfunction

  function automatic void track_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
    logic [ID_W-1:0] head;
    if (cmd == CMD_NONE || int'(id) >= NUM_IDS) begin
      log_event(RES_IGNORED, id);
    end else if (cmd == CMD_ACTIVATE) begin
      if (active_map[id] || waiting_map[id]) begin
        log_event(RES_IGNORED, id);
      end else if (active_total >= limit_cfg) begin
        append_waiting(id);
        log_event(RES_QUEUED, id);
      end else begin
        issue_or_fail(id);
      end
    end else if (active_map[id]) begin
      active_map[id] = 1'b0;
      active_total--;
      log_event(RES_FREED, id);
      if (waiting_total != 0) begin
        head = wait_head;
        remove_waiting(head);
        issue_or_fail(head);
      end
    end else if (cmd == CMD_CANCEL && waiting_map[id]) begin
      remove_waiting(id);
      log_event(RES_UNQUEUED, id);
    end else begin
      log_event(RES_IGNORED, id);
    end
    due_events[due_events.size()-1].last = 1'b1;
  endfunction

  function automatic logic [ID_W-1:0] pick_member(logic [NUM_IDS-1:0] mask);
    int base;
    base = $urandom_range(NUM_IDS - 1);
    for (int k = 0; k < NUM_IDS; k++) begin
      if (mask[(base + k) % NUM_IDS]) return ID_W'((base + k) % NUM_IDS);
    end
    return ID_W'($urandom_range(NUM_IDS - 1));
  endfunction

  always @(posedge clk) begin : check_events
    event_word_t want;
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      if (due_events.size() == 0) begin
        $error("unexpected event: event_res %0d event_id %0d", evt_ch.event_res,
               evt_ch.event_id);
        fail_count++;
      end else begin
        want = due_events[0];
        due_events.delete(0);
        if (evt_ch.event_res !== want.res) begin
          $error("event_res: expected %0d, got %0d", want.res, evt_ch.event_res);
          fail_count++;
        end
        if (evt_ch.event_id !== want.id) begin
          $error("event_id: expected %0d, got %0d", want.id, evt_ch.event_id);
          fail_count++;
        end
        if (evt_ch.active_count !== want.count) begin
          $error("active_count: expected %0d, got %0d", want.count, evt_ch.active_count);
          fail_count++;
        end
        if (evt_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, evt_ch.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      evt_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      evt_ch.ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else if (stall_left > 0) begin
      evt_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      evt_ch.ready <= 1'b1;
      stall_left = idle_gap();
    end
  end

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
    int gap;
    req_ch.valid  <= 1'b1;
    req_ch.cmd    <= cmd;
    req_ch.req_id <= id;
    do @(posedge clk); while (!req_ch.ready);
    track_request(cmd, id);
    gap = idle_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(int limit, bit on);
    wait_for_results();
    wr_en    <= 1'b1;
    wr_index <= REG_MAX_ACTIVE;
    wr_data  <= limit[CNT_W-1:0];
    @(posedge clk);
    wr_index <= REG_ONLINE;
    wr_data  <= CNT_W'(on);
    @(posedge clk);
    wr_en <= 1'b0;
    limit_cfg  = limit;
    online_cfg = on;
  endtask

  task automatic random_words(int count);
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    int               r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 45) begin
        cmd = CMD_ACTIVATE;
        id  = pick_member(~(active_map | waiting_map));
      end else if (r < 70) begin
        cmd = CMD_COMPLETE;
        id  = pick_member(active_map);
      end else if (r < 85) begin
        cmd = CMD_CANCEL;
        id  = pick_member(($urandom_range(1) == 1) ? waiting_map : active_map);
      end else begin
        cmd = CMD_W'($urandom_range(3));
        id  = ID_W'($urandom_range(NUM_IDS - 1));
      end
      send_word(cmd, id);
    end
  endtask

  task automatic test_queue_basics();
    set_config(1, 1'b1);
    send_word(CMD_ACTIVATE, 5'd0);
    send_word(CMD_ACTIVATE, 5'd31);
    send_word(CMD_ACTIVATE, 5'd0);
    send_word(CMD_ACTIVATE, 5'd31);
    send_word(CMD_ACTIVATE, 5'd5);
    send_word(CMD_ACTIVATE, 5'd10);
    send_word(CMD_CANCEL, 5'd5);
    send_word(CMD_COMPLETE, 5'd31);
    send_word(CMD_NONE, 5'd31);
    send_word(CMD_COMPLETE, 5'd0);
    send_word(CMD_CANCEL, 5'd0);
  endtask

  // With a limit of zero new ids wait, yet a freed slot still promotes.
  task automatic test_lowered_limit();
    set_config(0, 1'b1);
    send_word(CMD_ACTIVATE, 5'd3);
    send_word(CMD_COMPLETE, 5'd31);
    send_word(CMD_CANCEL, 5'd10);
  endtask

  task automatic test_offline_drain();
    send_word(CMD_ACTIVATE, 5'd7);
    send_word(CMD_ACTIVATE, 5'd8);
    send_word(CMD_ACTIVATE, 5'd9);
    set_config(0, 1'b0);
    send_word(CMD_COMPLETE, 5'd3);
    send_word(CMD_ACTIVATE, 5'd12);
    send_word(CMD_ACTIVATE, 5'd13);
    set_config(32, 1'b0);
    send_word(CMD_ACTIVATE, 5'd14);
  endtask

  task automatic test_random_mix();
    idle_on = 1'b1;
    set_config(4, 1'b1);
    random_words(70);
    idle_on = 1'b0;
    set_config(1, 1'b1);
    random_words(40);
    idle_on = 1'b1;
    set_config(32, 1'b1);
    random_words(50);
  endtask

  task automatic test_backpressure();
    set_config(8, 1'b1);
    hold_cnt = 400;
    random_words(30);
    wait_for_results();
  endtask

  task automatic test_offline_random();
    set_config(2, 1'b1);
    random_words(20);
    set_config(2, 1'b0);
    random_words(40);
  endtask

  task automatic test_zero_limit_random();
    set_config(0, 1'b1);
    random_words(20);
    set_config(16, 1'b1);
    random_words(40);
  endtask

  initial begin
    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_index      = REG_MAX_ACTIVE;
    wr_data       = '0;
    req_ch.valid  = 1'b0;
    req_ch.cmd    = CMD_ACTIVATE;
    req_ch.req_id = '0;
    evt_ch.ready  = 1'b0;
    fail_count    = 0;
    idle_on       = 1'b1;
    hold_cnt      = 0;
    stall_left    = 0;
    clear_tracker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_queue_basics();
    test_lowered_limit();
    test_offline_drain();
    test_random_mix();
    test_backpressure();
    test_offline_random();
    test_zero_limit_random();

    req_ch.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
